/* rtl/jos_pkg.sv */
// Shared constants and types for the Josephus elimination-order block.
package jos_pkg;

    localparam int MAX_PEOPLE = 64;
    localparam int IDX_W      = $clog2(MAX_PEOPLE);
    localparam int SIZE_W     = 7;
    localparam int STEP_W     = 8;
    localparam int START_W    = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_START,
        S_COUNT,
        S_EMIT,
        S_SEEK,
        S_LAST
    } t_state;

    typedef struct packed {
        logic init;
        logic hop;
        logic kill;
    } t_ring_cmd;

    typedef struct packed {
        t_ring_cmd              cmd;
        logic [IDX_W-1:0]       last_idx;
    } t_ring_ctl;

endpackage

/* rtl/josephus_elimination_order.sv */
// Top level of the Josephus elimination-order block: sequencer and ring of cells.
//
// One input beat starts a run over a ring of up to 64 people; the block then
// gives one result beat per person, in removal order, the survivor last with
// o_last_one set. A count token moves one ring position per cycle while the
// sequencer is stepping it (not while a result beat waits on i_out_stall)
// through a row of cells, removed positions included: it first walks from
// person 1 to the start position, then for each removal passes positions
// while counting step_count people still in the ring, holds for the result
// beat and then seeks the next person still in the ring; as the ring thins
// the count walks more and more empty positions. The next input beat is
// taken once the survivor beat has been accepted. Ring size 0 gives no
// results; ring size above 64 acts as 64, step or start of 0 as 1.
module josephus_elimination_order (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [jos_pkg::SIZE_W-1:0]      i_ring_size,
    input  logic [jos_pkg::STEP_W-1:0]      i_step_count,
    input  logic [jos_pkg::START_W-1:0]     i_start_pos,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [jos_pkg::SIZE_W-1:0]      o_person_label,
    output logic                            o_last_one
);

    jos_pkg::t_ring_ctl                 ctl;
    logic [jos_pkg::MAX_PEOPLE-1:0]     tok_fwd;
    logic [jos_pkg::MAX_PEOPLE-1:0]     tok_wrap;
    logic [jos_pkg::MAX_PEOPLE-1:0]     tok_in;
    logic [jos_pkg::MAX_PEOPLE-1:0]     hit_next;

    jos_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_ring_size    (i_ring_size),
        .i_step_count   (i_step_count),
        .i_start_pos    (i_start_pos),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_person_label (o_person_label),
        .o_last_one     (o_last_one),
        .i_next_alive   (|hit_next),
        .o_ctl          (ctl)
    );

    assign tok_in[0] = |tok_wrap;
    assign tok_in[jos_pkg::MAX_PEOPLE-1:1] = tok_fwd[jos_pkg::MAX_PEOPLE-2:0];

    for (genvar g = 0; g < jos_pkg::MAX_PEOPLE; g++) begin : g_cell
        jos_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (ctl.cmd),
            .i_member   (jos_pkg::IDX_W'(g) <= ctl.last_idx),
            .i_first    (g == 0),
            .i_last     (jos_pkg::IDX_W'(g) == ctl.last_idx),
            .i_tok      (tok_in[g]),
            .o_tok_fwd  (tok_fwd[g]),
            .o_tok_wrap (tok_wrap[g]),
            .o_hit_next (hit_next[g])
        );
    end

endmodule

/* rtl/jos_cell.sv */
// One ring position: alive flag and the circulating count token.
module jos_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jos_pkg::t_ring_cmd  i_cmd,
    input  logic                i_member,
    input  logic                i_first,
    input  logic                i_last,
    input  logic                i_tok,
    output logic                o_tok_fwd,
    output logic                o_tok_wrap,
    output logic                o_hit_next
);

    logic r_alive;
    logic r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
            r_tok   <= 1'b0;
        end else if (i_cmd.init) begin
            r_alive <= i_member;
            r_tok   <= i_first;
        end else begin
            if (i_cmd.hop) begin
                r_tok <= i_tok;
            end
            if (i_cmd.kill) begin
                r_alive <= r_alive & ~r_tok;
            end
        end
    end

    assign o_tok_fwd  = r_tok & ~i_last;
    assign o_tok_wrap = r_tok & i_last;
    assign o_hit_next = i_tok & r_alive;

endmodule

/* rtl/jos_ctrl.sv */
// Run sequencer: start offset, step counting, removal and result beats.
module jos_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [jos_pkg::SIZE_W-1:0]      i_ring_size,
    input  logic [jos_pkg::STEP_W-1:0]      i_step_count,
    input  logic [jos_pkg::START_W-1:0]     i_start_pos,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [jos_pkg::SIZE_W-1:0]      o_person_label,
    output logic                            o_last_one,
    input  logic                            i_next_alive,
    output jos_pkg::t_ring_ctl              o_ctl
);

    jos_pkg::t_state                r_state, n_state;
    logic [jos_pkg::IDX_W-1:0]      r_pos;
    logic [jos_pkg::IDX_W-1:0]      r_last_idx;
    logic [jos_pkg::STEP_W-1:0]     r_step;
    logic [jos_pkg::STEP_W-1:0]     r_cnt;
    logic [jos_pkg::START_W-1:0]    r_hops;
    logic [jos_pkg::SIZE_W-1:0]     r_rem;

    logic [jos_pkg::SIZE_W-1:0]     sat_size;
    logic [jos_pkg::STEP_W-1:0]     eff_step;
    logic [jos_pkg::START_W-1:0]    eff_start;
    logic                           in_acc;
    logic                           to_count;
    jos_pkg::t_ring_cmd             cmd;

    assign sat_size  = (i_ring_size > jos_pkg::SIZE_W'(jos_pkg::MAX_PEOPLE))
                     ? jos_pkg::SIZE_W'(jos_pkg::MAX_PEOPLE) : i_ring_size;
    assign eff_step  = (i_step_count == '0) ? jos_pkg::STEP_W'(1) : i_step_count;
    assign eff_start = (i_start_pos == '0) ? jos_pkg::START_W'(1) : i_start_pos;
    assign in_acc    = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            jos_pkg::S_IDLE: begin
                if (in_acc && i_ring_size != '0) n_state = jos_pkg::S_INIT;
            end
            jos_pkg::S_INIT:  n_state = jos_pkg::S_START;
            jos_pkg::S_START: begin
                if (r_hops == '0) begin
                    n_state = (r_rem > jos_pkg::SIZE_W'(1)) ? jos_pkg::S_COUNT
                                                            : jos_pkg::S_LAST;
                end
            end
            jos_pkg::S_COUNT: begin
                if (r_cnt == '0) n_state = jos_pkg::S_EMIT;
            end
            jos_pkg::S_EMIT: begin
                if (!i_out_stall) n_state = jos_pkg::S_SEEK;
            end
            jos_pkg::S_SEEK: begin
                if (i_next_alive) begin
                    n_state = (r_rem == jos_pkg::SIZE_W'(1)) ? jos_pkg::S_LAST
                                                             : jos_pkg::S_COUNT;
                end
            end
            jos_pkg::S_LAST: begin
                if (!i_out_stall) n_state = jos_pkg::S_IDLE;
            end
            default: n_state = jos_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd.init    = 1'b0;
        cmd.hop     = 1'b0;
        cmd.kill    = 1'b0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_last_one  = 1'b0;
        case (r_state)
            jos_pkg::S_IDLE:  o_in_stall = !i_rst_n;
            jos_pkg::S_INIT:  cmd.init = 1'b1;
            jos_pkg::S_START: cmd.hop = (r_hops != '0);
            jos_pkg::S_COUNT: cmd.hop = (r_cnt != '0);
            jos_pkg::S_EMIT: begin
                o_out_valid = 1'b1;
                cmd.kill    = !i_out_stall;
            end
            jos_pkg::S_SEEK:  cmd.hop = 1'b1;
            jos_pkg::S_LAST: begin
                o_out_valid = 1'b1;
                o_last_one  = 1'b1;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    assign to_count = (n_state == jos_pkg::S_COUNT) && (r_state != jos_pkg::S_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jos_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == jos_pkg::S_IDLE && in_acc) begin
            r_last_idx <= jos_pkg::IDX_W'(sat_size - jos_pkg::SIZE_W'(1));
            r_step     <= eff_step;
            r_hops     <= eff_start - jos_pkg::START_W'(1);
            r_rem      <= sat_size;
        end
        if (cmd.init) begin
            r_pos <= '0;
        end
        if (cmd.hop) begin
            r_pos <= (r_pos == r_last_idx) ? '0 : r_pos + jos_pkg::IDX_W'(1);
        end
        if (r_state == jos_pkg::S_START && cmd.hop) begin
            r_hops <= r_hops - jos_pkg::START_W'(1);
        end
        if (r_state == jos_pkg::S_COUNT && cmd.hop && i_next_alive) begin
            r_cnt <= r_cnt - jos_pkg::STEP_W'(1);
        end
        if (to_count) begin
            r_cnt <= r_step - jos_pkg::STEP_W'(1);
        end
        if (cmd.kill) begin
            r_rem <= r_rem - jos_pkg::SIZE_W'(1);
        end
    end

    assign o_person_label = jos_pkg::SIZE_W'(r_pos) + jos_pkg::SIZE_W'(1);
    assign o_ctl.cmd      = cmd;
    assign o_ctl.last_idx = r_last_idx;

endmodule
